[rtl/fass_pkg.sv]
// Shared types, constants and helper functions for the flap ADC synthesizer.
package fass_pkg;

  localparam int ROW_DEPTH_DEF = 512;
  localparam int MAX_CHG_DEF   = 8;
  localparam int DETENTS       = 4;
  localparam int NUM_DET_REGS  = 4;

  localparam int ANG_W     = 8;
  localparam int PAY_W     = 32;
  localparam int POT_W     = 16;
  localparam int DET_W     = 24;
  localparam int DCNT_W    = 3;
  localparam int HW_W      = 9;
  localparam int D_W       = 10;
  localparam int T_W       = 12;
  localparam int TICK_W    = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 24;

  // shared multiplier and serial divider widths
  localparam int MA_W  = 30;
  localparam int MB_W  = 16;
  localparam int MP_W  = 46;
  localparam int DVD_W = 48;
  localparam int DVS_W = 31;
  localparam int Q_W   = 16;

  localparam int Q_DEPTH = 2;
  localparam int QP_W    = 1;

  localparam logic [HW_W-1:0] HALF_WIN_RST = 9'd100;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DET0     = 3'd0,
    REG_DET1     = 3'd1,
    REG_DET2     = 3'd2,
    REG_DET3     = 3'd3,
    REG_DET_CNT  = 3'd4,
    REG_HALF_WIN = 3'd5,
    REG_RAW_MODE = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [NUM_DET_REGS-1:0][DET_W-1:0] det;
    logic [DCNT_W-1:0]                  det_cnt;
    logic [HW_W-1:0]                    half;
    logic                               raw;
  } cfg_t;

  typedef enum logic [1:0] {
    K_ROW,
    K_RAW,
    K_DRAIN
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [ANG_W-1:0]  angle;
    logic [PAY_W-1:0]  payload;
    logic              present;
    logic [POT_W-1:0]  adc;
    logic [POT_W-1:0]  pot;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  // first matching detent wins; no match gives zero
  function automatic logic [POT_W-1:0] pot_for(input logic [ANG_W-1:0] angle,
                                               input cfg_t cfg);
    logic [DCNT_W-1:0] n;
    logic [POT_W-1:0]  res;
    n   = (cfg.det_cnt > DCNT_W'(DETENTS)) ? DCNT_W'(DETENTS) : cfg.det_cnt;
    res = '0;
    for (int i = NUM_DET_REGS - 1; i >= 0; i--) begin
      if ((DCNT_W'(i) < n) && (cfg.det[i][DET_W-1:POT_W] == angle)) begin
        res = cfg.det[i][POT_W-1:0];
      end
    end
    return res;
  endfunction

  function automatic logic [HW_W-1:0] eff_half(input cfg_t cfg);
    return (cfg.half == '0) ? HW_W'(1) : cfg.half;
  endfunction

endpackage

[rtl/flap_adc_smoothstep_synth.sv]
// Top level of the flap potentiometer ADC synthesizer.
//
// Channels: in_* carries one log row (func 0) or a drain request (func 1);
// out_* carries emitted rows; cfg_* writes the seven configuration registers
// (index 0..6), always ready. All channels transfer on valid and ready high.
// Raw mode: a row passes from the queue through the back end's output state
// into the output register.
// Synth mode: rows are held in a ring store and leave once half_window rows
// are queued behind them, or one per drain. An emitting row is read from the
// store and passes a serial scan of the change table, which also updates the
// recorded change count; if a change window covers the row, 6 multiplier
// steps and the serial divider follow. A row that brings a change while the
// change table is full first shifts out the table's oldest record.
// A two-entry queue sits behind the input, so up to two items transfer while
// the back end works or the output register waits.
// Reset (rst_n low, synchronous) empties store, table and queue; no
// clearing pass. A stalled receiver holds the result in the output
// register; the back end then stops, and input stalls once the queue fills.
module flap_adc_smoothstep_synth import fass_pkg::*; #(
  parameter int ROW_DEPTH   = ROW_DEPTH_DEF,
  parameter int MAX_CHANGES = MAX_CHG_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_func,
  input  logic [ANG_W-1:0]     in_flap_deg,
  input  logic [PAY_W-1:0]     in_payload,
  input  logic                 in_raw_adc_present,
  input  logic [POT_W-1:0]     in_raw_adc,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [ANG_W-1:0]     out_flap_deg,
  output logic [PAY_W-1:0]     out_payload,
  output logic                 out_adc_present,
  output logic [POT_W-1:0]     out_adc_value,
  output logic                 out_drain_last,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  cfg_t   cfg;
  qstat_t q_stat;
  logic   q_push;
  logic   q_pop;
  item_t  q_item;
  item_t  q_head;

  fass_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_func            (in_func),
    .in_flap_deg        (in_flap_deg),
    .in_payload         (in_payload),
    .in_raw_adc_present (in_raw_adc_present),
    .in_raw_adc         (in_raw_adc),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .q_stat             (q_stat),
    .q_push             (q_push),
    .q_item             (q_item),
    .cfg                (cfg)
  );

  fass_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_item),
    .pop       (q_pop),
    .head      (q_head),
    .stat      (q_stat)
  );

  fass_back #(
    .ROW_DEPTH   (ROW_DEPTH),
    .MAX_CHANGES (MAX_CHANGES)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg),
    .q_stat          (q_stat),
    .q_head          (q_head),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_flap_deg    (out_flap_deg),
    .out_payload     (out_payload),
    .out_adc_present (out_adc_present),
    .out_adc_value   (out_adc_value),
    .out_drain_last  (out_drain_last)
  );

endmodule

[rtl/fass_front.sv]
// Front end: configuration registers, input acceptance and item classification.
module fass_front import fass_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_func,
  input  logic [ANG_W-1:0]     in_flap_deg,
  input  logic [PAY_W-1:0]     in_payload,
  input  logic                 in_raw_adc_present,
  input  logic [POT_W-1:0]     in_raw_adc,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data,
  input  qstat_t               q_stat,
  output logic                 q_push,
  output item_t                q_item,
  output cfg_t                 cfg
);

  cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.det     <= '0;
      cfg_r.det_cnt <= '0;
      cfg_r.half    <= HALF_WIN_RST;
      cfg_r.raw     <= 1'b0;
    end else if (cfg_valid) begin
      case (reg_idx_t'(cfg_index))
        REG_DET0:     cfg_r.det[0]  <= cfg_data;
        REG_DET1:     cfg_r.det[1]  <= cfg_data;
        REG_DET2:     cfg_r.det[2]  <= cfg_data;
        REG_DET3:     cfg_r.det[3]  <= cfg_data;
        REG_DET_CNT:  cfg_r.det_cnt <= cfg_data[DCNT_W-1:0];
        REG_HALF_WIN: cfg_r.half    <= cfg_data[HW_W-1:0];
        REG_RAW_MODE: cfg_r.raw     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign in_ready = !q_stat.full;
  // a drain in raw mode is taken and dropped here
  assign q_push   = in_valid && in_ready && !(in_func && cfg_r.raw);

  always_comb begin
    q_item.kind    = in_func ? K_DRAIN : (cfg_r.raw ? K_RAW : K_ROW);
    q_item.angle   = in_flap_deg;
    q_item.payload = in_payload;
    q_item.present = in_raw_adc_present;
    q_item.adc     = in_raw_adc_present ? in_raw_adc : '0;
    q_item.pot     = pot_for(in_flap_deg, cfg_r);
  end

endmodule

[rtl/fass_queue.sv]
// Two-entry queue between the front end and the back end.
module fass_queue import fass_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  item_t  push_item,
  input  logic   pop,
  output item_t  head,
  output qstat_t stat
);

  item_t           slot_r [Q_DEPTH];
  logic [QP_W-1:0] wp_r;
  logic [QP_W-1:0] rp_r;
  logic [QP_W:0]   cnt_r;
  logic            do_push;
  logic            do_pop;

  assign stat.full  = (cnt_r == (QP_W+1)'(Q_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head       = slot_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= wp_r + QP_W'(1);
      if (do_pop)  rp_r <= rp_r + QP_W'(1);
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + (QP_W+1)'(1);
        2'b01:   cnt_r <= cnt_r - (QP_W+1)'(1);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slot_r[wp_r] <= push_item;
  end

endmodule

[rtl/fass_div.sv]
// Restoring divider, one quotient bit per cycle.
module fass_div import fass_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [Q_W-1:0]   quot
);

  localparam int CNT_W = $clog2(Q_W + 1);

  logic [DVS_W:0]   rem_r;
  logic [DVS_W-1:0] dvs_r;
  logic [Q_W-1:0]   low_r;
  logic [Q_W-1:0]   q_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DVS_W:0]   trial;
  logic             ge;

  // quotient fits Q_W bits, so the remainder stays below the divisor
  assign trial = {rem_r[DVS_W-1:0], low_r[Q_W-1]};
  assign ge    = trial >= {1'b0, dvs_r};
  assign done  = done_r;
  assign quot  = q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(Q_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= dividend[DVD_W-1:Q_W];
      low_r <= dividend[Q_W-1:0];
      dvs_r <= divisor;
      q_r   <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? (trial - {1'b0, dvs_r}) : trial;
      low_r <= {low_r[Q_W-2:0], 1'b0};
      q_r   <= {q_r[Q_W-2:0], ge};
    end
  end

endmodule

[rtl/fass_back.sv]
// Back end: tick counter, row delay store, change table, blend and output register.
module fass_back import fass_pkg::*; #(
  parameter int ROW_DEPTH   = ROW_DEPTH_DEF,
  parameter int MAX_CHANGES = MAX_CHG_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  cfg_t             cfg,
  input  qstat_t           q_stat,
  input  item_t            q_head,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [ANG_W-1:0] out_flap_deg,
  output logic [PAY_W-1:0] out_payload,
  output logic             out_adc_present,
  output logic [POT_W-1:0] out_adc_value,
  output logic             out_drain_last
);

  localparam int RA_W   = $clog2(ROW_DEPTH);
  localparam int FILL_W = $clog2(ROW_DEPTH + 1);
  localparam int CI_W   = (MAX_CHANGES > 1) ? $clog2(MAX_CHANGES) : 1;
  localparam int CC_W   = $clog2(MAX_CHANGES + 1);
  localparam int ROW_W  = ANG_W + PAY_W;

  typedef struct packed {
    logic [TICK_W-1:0] snap;
    logic [POT_W-1:0]  prev;
    logic [POT_W-1:0]  next;
  } chg_t;

  typedef enum logic [4:0] {
    S_IDLE, S_SHRD, S_SHWR, S_CHK, S_EMIT, S_SCAN, S_SCAN2,
    S_MUL1, S_MUL2, S_MUL3, S_MUL4, S_MUL5, S_MUL6, S_DIVGO, S_DIVW, S_OUT
  } state_t;

  state_t            state_r;
  logic [TICK_W-1:0] tick_r;
  logic [RA_W-1:0]   head_r;
  logic [FILL_W-1:0] fill_r;
  logic              last_valid_r;
  logic [ANG_W-1:0]  last_angle_r;
  logic [CC_W-1:0]   cnt_r;
  logic [CI_W-1:0]   sh_i_r;
  logic [CC_W-1:0]   i_r;
  logic [CC_W-1:0]   keep_r;
  chg_t              new_rec_r;
  logic              drain_r;
  logic [TICK_W-1:0] emit_r;
  logic              hit_r;
  logic [D_W-1:0]    n_r;
  logic [POT_W-1:0]  prev_r;
  logic [POT_W-1:0]  next_r;
  logic [19:0]       nn_r;
  logic [19:0]       dd_r;
  logic [MA_W-1:0]   w_r;
  logic [MA_W-1:0]   d3_r;
  logic [MP_W-1:0]   p1_r;
  logic [MP_W-1:0]   p2_r;
  logic [ANG_W-1:0]  res_angle_r;
  logic [PAY_W-1:0]  res_pay_r;
  logic              res_present_r;
  logic [POT_W-1:0]  res_adc_r;
  logic              res_last_r;

  logic              out_valid_r;
  logic [ANG_W-1:0]  out_angle_r;
  logic [PAY_W-1:0]  out_pay_r;
  logic              out_present_r;
  logic [POT_W-1:0]  out_adc_r;
  logic              out_last_r;

  logic [ROW_W-1:0]  store_mem [ROW_DEPTH];
  logic [ROW_W-1:0]  st_q;
  logic              st_we;
  logic              st_re;
  logic [RA_W-1:0]   st_waddr;

  chg_t              chg_mem [MAX_CHANGES];
  chg_t              cm_q;
  logic              cm_we;
  logic              cm_re;
  logic [CI_W-1:0]   cm_waddr;
  logic [CI_W-1:0]   cm_raddr;
  chg_t              cm_wdata;

  logic [HW_W-1:0]   h_eff;
  logic [D_W-1:0]    d;
  logic [FILL_W-1:0] cap;
  logic [RA_W:0]     wsum;
  logic [RA_W-1:0]   head_inc;
  logic              chg_ev;
  chg_t              new_rec;
  logic [TICK_W-1:0] dlt;
  logic [TICK_W-1:0] off;
  logic              hit;
  logic              keep;
  logic [T_W-1:0]    t_fac;
  logic [MA_W-1:0]   mul_a;
  logic [MB_W-1:0]   mul_b;
  logic [MP_W-1:0]   mul_p;
  logic              div_start;
  logic [DVD_W-1:0]  div_dvd;
  logic [DVS_W-1:0]  div_dvs;
  logic              div_done;
  logic [Q_W-1:0]    div_q;
  logic              can_out;
  logic              out_load;

  assign h_eff = eff_half(cfg);
  assign d     = {h_eff, 1'b0};

  always_comb begin
    if ((32'(h_eff) + 32'd1) > 32'(ROW_DEPTH)) cap = FILL_W'(ROW_DEPTH);
    else                                       cap = FILL_W'(32'(h_eff) + 32'd1);
  end

  // ring store address wrap for arbitrary depth
  assign wsum     = {1'b0, head_r} + (RA_W+1)'(fill_r);
  assign st_waddr = (wsum >= (RA_W+1)'(ROW_DEPTH)) ?
                    RA_W'(wsum - (RA_W+1)'(ROW_DEPTH)) : wsum[RA_W-1:0];
  assign head_inc = (head_r == RA_W'(ROW_DEPTH - 1)) ? '0 : head_r + RA_W'(1);

  assign q_pop  = (state_r == S_IDLE) && !q_stat.empty;
  assign chg_ev = last_valid_r && (q_head.angle != last_angle_r);
  assign st_we  = q_pop && (q_head.kind == K_ROW);
  assign st_re  = (state_r == S_EMIT);

  always_comb begin
    new_rec.snap = tick_r + TICK_W'(1);
    new_rec.prev = pot_for(last_angle_r, cfg);
    new_rec.next = q_head.pot;
  end

  // window test and expiry test for the entry under scan
  assign dlt  = emit_r - cm_q.snap;
  assign off  = dlt + TICK_W'(h_eff);
  assign hit  = off <= TICK_W'(d);
  assign keep = dlt[TICK_W-1] || (dlt <= TICK_W'(h_eff));

  always_comb begin
    cm_we    = 1'b0;
    cm_re    = 1'b0;
    cm_waddr = '0;
    cm_raddr = '0;
    cm_wdata = cm_q;
    case (state_r)
      S_IDLE: begin
        if (st_we && chg_ev && (cnt_r < CC_W'(MAX_CHANGES))) begin
          cm_we    = 1'b1;
          cm_waddr = cnt_r[CI_W-1:0];
          cm_wdata = new_rec;
        end
      end
      S_SHRD: begin
        if (sh_i_r == CI_W'(MAX_CHANGES - 1)) begin
          cm_we    = 1'b1;
          cm_waddr = sh_i_r;
          cm_wdata = new_rec_r;
        end else begin
          cm_re    = 1'b1;
          cm_raddr = sh_i_r + CI_W'(1);
        end
      end
      S_SHWR: begin
        cm_we    = 1'b1;
        cm_waddr = sh_i_r;
      end
      S_SCAN: begin
        if (i_r < cnt_r) begin
          cm_re    = 1'b1;
          cm_raddr = i_r[CI_W-1:0];
        end
      end
      S_SCAN2: begin
        if (keep) begin
          cm_we    = 1'b1;
          cm_waddr = keep_r[CI_W-1:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (st_we) store_mem[st_waddr] <= {q_head.angle, q_head.payload};
    if (st_re) st_q <= store_mem[head_r];
  end

  always_ff @(posedge clk) begin
    if (cm_we) chg_mem[cm_waddr] <= cm_wdata;
    if (cm_re) cm_q <= chg_mem[cm_raddr];
  end

  // shared multiplier: one product per state
  assign t_fac = ({2'b0, d} << 1) + {2'b0, d} - ({2'b0, n_r} << 1);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_MUL1: begin mul_a = MA_W'(n_r);     mul_b = MB_W'(n_r);   end
      S_MUL2: begin mul_a = MA_W'(d);       mul_b = MB_W'(d);     end
      S_MUL3: begin mul_a = MA_W'(nn_r);    mul_b = MB_W'(t_fac); end
      S_MUL4: begin mul_a = MA_W'(dd_r);    mul_b = MB_W'(d);     end
      S_MUL5: begin mul_a = d3_r - w_r;     mul_b = prev_r;       end
      S_MUL6: begin mul_a = w_r;            mul_b = next_r;       end
      default: ;
    endcase
  end

  assign mul_p = MP_W'(mul_a) * MP_W'(mul_b);

  // round half up: (2*num + D^3) / (2*D^3)
  assign div_start = (state_r == S_DIVGO);
  assign div_dvd   = {1'b0, p1_r + p2_r, 1'b0} + DVD_W'(d3_r);
  assign div_dvs   = {d3_r, 1'b0};

  fass_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quot     (div_q)
  );

  assign can_out  = !out_valid_r || out_ready;
  assign out_load = (state_r == S_OUT) && can_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      tick_r       <= '0;
      head_r       <= '0;
      fill_r       <= '0;
      last_valid_r <= 1'b0;
      cnt_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (out_load)       out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (!q_stat.empty) begin
            res_angle_r <= q_head.angle;
            res_pay_r   <= q_head.payload;
            case (q_head.kind)
              K_RAW: begin
                tick_r        <= tick_r + TICK_W'(1);
                res_present_r <= q_head.present;
                res_adc_r     <= q_head.adc;
                res_last_r    <= 1'b0;
                state_r       <= S_OUT;
              end
              K_DRAIN: begin
                drain_r <= 1'b1;
                if (fill_r != '0) state_r <= S_EMIT;
              end
              K_ROW: begin
                tick_r       <= tick_r + TICK_W'(1);
                fill_r       <= fill_r + FILL_W'(1);
                last_valid_r <= 1'b1;
                last_angle_r <= q_head.angle;
                drain_r      <= 1'b0;
                state_r      <= S_CHK;
                if (chg_ev) begin
                  if (cnt_r >= CC_W'(MAX_CHANGES)) begin
                    // table full: shift out the oldest record first
                    new_rec_r <= new_rec;
                    sh_i_r    <= '0;
                    state_r   <= S_SHRD;
                  end else begin
                    cnt_r <= cnt_r + CC_W'(1);
                  end
                end
              end
              default: ;
            endcase
          end
        end
        S_SHRD: begin
          if (sh_i_r == CI_W'(MAX_CHANGES - 1)) begin
            cnt_r   <= CC_W'(MAX_CHANGES);
            state_r <= S_CHK;
          end else begin
            state_r <= S_SHWR;
          end
        end
        S_SHWR: begin
          sh_i_r  <= sh_i_r + CI_W'(1);
          state_r <= S_SHRD;
        end
        S_CHK: begin
          state_r <= (fill_r >= cap) ? S_EMIT : S_IDLE;
        end
        S_EMIT: begin
          emit_r  <= tick_r - TICK_W'(fill_r) + TICK_W'(1);
          head_r  <= head_inc;
          fill_r  <= fill_r - FILL_W'(1);
          i_r     <= '0;
          keep_r  <= '0;
          hit_r   <= 1'b0;
          state_r <= S_SCAN;
        end
        S_SCAN: begin
          if (i_r < cnt_r) begin
            state_r <= S_SCAN2;
          end else begin
            cnt_r         <= keep_r;
            res_angle_r   <= st_q[ROW_W-1:PAY_W];
            res_pay_r     <= st_q[PAY_W-1:0];
            res_present_r <= 1'b1;
            res_last_r    <= drain_r && (fill_r == '0);
            res_adc_r     <= pot_for(st_q[ROW_W-1:PAY_W], cfg);
            state_r       <= hit_r ? S_MUL1 : S_OUT;
          end
        end
        S_SCAN2: begin
          i_r <= i_r + CC_W'(1);
          // later hits overwrite earlier ones
          if (hit) begin
            hit_r  <= 1'b1;
            n_r    <= off[D_W-1:0];
            prev_r <= cm_q.prev;
            next_r <= cm_q.next;
          end
          if (keep) keep_r <= keep_r + CC_W'(1);
          state_r <= S_SCAN;
        end
        S_MUL1: begin nn_r <= mul_p[19:0];     state_r <= S_MUL2; end
        S_MUL2: begin dd_r <= mul_p[19:0];     state_r <= S_MUL3; end
        S_MUL3: begin w_r  <= mul_p[MA_W-1:0]; state_r <= S_MUL4; end
        S_MUL4: begin d3_r <= mul_p[MA_W-1:0]; state_r <= S_MUL5; end
        S_MUL5: begin p1_r <= mul_p;           state_r <= S_MUL6; end
        S_MUL6: begin p2_r <= mul_p;           state_r <= S_DIVGO; end
        S_DIVGO: state_r <= S_DIVW;
        S_DIVW: begin
          if (div_done) begin
            res_adc_r <= div_q;
            state_r   <= S_OUT;
          end
        end
        S_OUT: begin
          if (can_out) begin
            out_angle_r   <= res_angle_r;
            out_pay_r     <= res_pay_r;
            out_present_r <= res_present_r;
            out_adc_r     <= res_adc_r;
            out_last_r    <= res_last_r;
            state_r       <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_flap_deg    = out_angle_r;
  assign out_payload     = out_pay_r;
  assign out_adc_present = out_present_r;
  assign out_adc_value   = out_adc_r;
  assign out_drain_last  = out_last_r;

`ifndef NO_ASSERTIONS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(ROW_DEPTH))
    else $error("row store fill above depth");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CC_W'(MAX_CHANGES))
    else $error("change count above table size");

  a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
    head_r < RA_W'(ROW_DEPTH - 1) || head_r == RA_W'(ROW_DEPTH - 1))
    else $error("store head out of range");

  a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EMIT |-> fill_r != '0)
    else $error("emit from empty store");

  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && can_out) |=> out_valid_r && state_r == S_IDLE)
    else $error("result not loaded into output register");
`endif

endmodule
